FILE: rtl/core/fiid_pkg.sv
`default_nettype none
package fiid_pkg;

    // Sizing
    localparam int WINDOW_DEPTH   = 24;
    localparam int CONTEXT_SLOTS  = 16;
    localparam int WARMUP_WINDOWS = 2;

    localparam int ADDR_W     = 32;
    localparam int INTERVAL_W = 32;
    localparam int MISSED_W   = 8;
    localparam int STATUS_W   = 3;
    localparam int MEAN_W     = 32;
    localparam int CTX_SLOT_W = 4;
    localparam int THRESH_W   = 32;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 32'd100;

    localparam int SLOT_W     = (CONTEXT_SLOTS > 1) ? $clog2(CONTEXT_SLOTS) : 1;
    localparam int CUR_W      = $clog2(WINDOW_DEPTH);
    localparam int WARM_W     = $clog2(WARMUP_WINDOWS + 1);
    localparam int SUM_W      = INTERVAL_W + $clog2(WINDOW_DEPTH);
    localparam int RING_DEPTH = CONTEXT_SLOTS * WINDOW_DEPTH;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Divide-by-window unit: quotient bits retired per cycle
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (SUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEPS;
    localparam int REM_W      = $clog2(WINDOW_DEPTH) + 1;
    localparam int DCNT_W     = $clog2(DIV_CYCLES + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_NOT_SLAVE = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEARNING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NORMAL    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INJECTION = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0]     access_address;
        logic                  is_slave;
        logic                  interval_valid;
        logic [INTERVAL_W-1:0] frame_interval;
        logic [MISSED_W-1:0]   missed_packets;
    } in_item_t;

    // ring_op set: back does the window work; else status is final
    typedef struct packed {
        logic                  ring_op;
        logic                  new_ctx;
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic [INTERVAL_W-1:0] interval;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [MEAN_W-1:0]     window_mean;
        logic [CTX_SLOT_W-1:0] context_slot;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/fiid_ram.sv
`default_nettype none
module fiid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

FILE: rtl/core/fiid_front.sv
`default_nettype none
module fiid_front (
    input  wire logic             clk,
    input  wire logic             rstn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fiid_pkg::in_item_t in_item,
    output logic                  q_push,
    output fiid_pkg::cmd_t        q_cmd,
    input  wire logic             q_full
);
    import fiid_pkg::*;

    logic [ADDR_W-1:0] key_reg       [CONTEXT_SLOTS];
    logic [ADDR_W-1:0] key_next      [CONTEXT_SLOTS];
    logic [CONTEXT_SLOTS-1:0] key_valid_reg;
    logic [CONTEXT_SLOTS-1:0] key_valid_next;

    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
    logic              accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    // lowest matching slot and lowest free slot
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int i = CONTEXT_SLOTS - 1; i >= 0; i--) begin
            if (key_valid_reg[i] && key_reg[i] == in_item.access_address) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (!key_valid_reg[i]) begin
                free     = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        key_next       = key_reg;
        key_valid_next = key_valid_reg;
        q_cmd.ring_op  = 1'b0;
        q_cmd.new_ctx  = 1'b0;
        q_cmd.status   = ST_NOT_SLAVE;
        q_cmd.slot     = '0;
        q_cmd.interval = in_item.frame_interval;
        if (in_item.is_slave) begin
            if (hit || free) begin
                q_cmd.slot = hit ? hit_idx : free_idx;
                if (!hit) begin
                    q_cmd.new_ctx = 1'b1;
                    if (accept) begin
                        key_next[free_idx]       = in_item.access_address;
                        key_valid_next[free_idx] = 1'b1;
                    end
                end
                if (!in_item.interval_valid || in_item.missed_packets != '0) begin
                    q_cmd.status = ST_SKIPPED;
                end else begin
                    q_cmd.ring_op = 1'b1;
                    q_cmd.status  = ST_LEARNING;
                end
            end else begin
                q_cmd.status = ST_FULL;
            end
        end
    end

    always_ff @(posedge clk) begin
        key_reg <= key_next;
        if (!rstn) begin
            key_valid_reg <= '0;
        end else begin
            key_valid_reg <= key_valid_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/fiid_queue.sv
`default_nettype none
module fiid_queue (
    input  wire logic           clk,
    input  wire logic           rstn,
    input  wire logic           push,
    input  wire fiid_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output fiid_pkg::cmd_t      pop_cmd,
    output logic                not_empty
);
    import fiid_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/fiid_back.sv
`default_nettype none
module fiid_back (
    input  wire logic                          clk,
    input  wire logic                          rstn,
    input  wire logic                          cmd_valid,
    input  wire fiid_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    input  wire logic [fiid_pkg::THRESH_W-1:0] threshold,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output fiid_pkg::result_t                  out_result
);
    import fiid_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [CUR_W-1:0]      cursor_reg [CONTEXT_SLOTS];
    logic [CUR_W-1:0]      cursor_next [CONTEXT_SLOTS];
    logic [WARM_W-1:0]     warm_reg [CONTEXT_SLOTS];
    logic [WARM_W-1:0]     warm_next [CONTEXT_SLOTS];
    logic [SUM_W-1:0]      sum_reg [CONTEXT_SLOTS];
    logic [SUM_W-1:0]      sum_next [CONTEXT_SLOTS];
    logic [INTERVAL_W-1:0] old_reg, old_next;
    logic [DIV_W-1:0]      div_q_reg, div_q_next;
    logic [REM_W-1:0]      div_rem_reg, div_rem_next;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;
    result_t               res_reg, res_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [CUR_W-1:0]      cur;
    logic [WARM_W-1:0]     warm;
    logic [SUM_W-1:0]      sum;
    logic [RING_AW-1:0]    ring_addr;
    logic                  ram_we;
    logic [INTERVAL_W-1:0] ram_rdata;
    logic [INTERVAL_W-1:0] old_val;
    logic [DIV_W-1:0]      step_q;
    logic [REM_W-1:0]      step_rem;
    logic [MEAN_W-1:0]     mean;
    logic [MEAN_W:0]       limit;
    logic [CUR_W-1:0]      cur_inc;

    assign cur       = cursor_reg[cmd_reg.slot];
    assign warm      = warm_reg[cmd_reg.slot];
    assign sum       = sum_reg[cmd_reg.slot];
    assign ring_addr = RING_AW'(cmd_reg.slot * WINDOW_DEPTH) + RING_AW'(cur);
    assign cur_inc   = (cur == CUR_W'(WINDOW_DEPTH - 1)) ? '0 : cur + 1'b1;
    assign mean      = div_q_reg[MEAN_W-1:0];
    assign limit     = {1'b0, mean} + {1'b0, threshold};
    assign old_val   = (warm == '0) ? '0 : ram_rdata;

    fiid_ram #(
        .WIDTH (INTERVAL_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_addr),
        .wdata (cmd_reg.interval),
        .raddr (ring_addr),
        .rdata (ram_rdata)
    );

    // restoring division by the window depth, DIV_STEPS bits per cycle
    always_comb begin
        step_q   = div_q_reg;
        step_rem = div_rem_reg;
        for (int k = 0; k < DIV_STEPS; k++) begin
            step_rem = {step_rem[REM_W-2:0], step_q[DIV_W-1]};
            step_q   = {step_q[DIV_W-2:0], 1'b0};
            if (step_rem >= REM_W'(WINDOW_DEPTH)) begin
                step_rem  = step_rem - REM_W'(WINDOW_DEPTH);
                step_q[0] = 1'b1;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cursor_next    = cursor_reg;
        warm_next      = warm_reg;
        sum_next       = sum_reg;
        old_next       = old_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    if (cmd.new_ctx) begin
                        cursor_next[cmd.slot] = '0;
                        warm_next[cmd.slot]   = '0;
                        sum_next[cmd.slot]    = '0;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                res_next.status       = cmd_reg.status;
                res_next.window_mean  = '0;
                res_next.context_slot = CTX_SLOT_W'(cmd_reg.slot);
                // ring read address is presented here
                state_next = cmd_reg.ring_op ? S_READ : S_OUT;
            end
            S_READ: begin
                old_next = old_val;
                if (warm < WARM_W'(WARMUP_WINDOWS)) begin
                    ram_we                    = 1'b1;
                    sum_next[cmd_reg.slot]    = sum - SUM_W'(old_val)
                                                + SUM_W'(cmd_reg.interval);
                    cursor_next[cmd_reg.slot] = cur_inc;
                    if (cur == CUR_W'(WINDOW_DEPTH - 1)) begin
                        warm_next[cmd_reg.slot] = warm + 1'b1;
                    end
                    res_next.status = ST_LEARNING;
                    state_next      = S_OUT;
                end else begin
                    div_q_next   = DIV_W'(sum);
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                div_q_next   = step_q;
                div_rem_next = step_rem;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(DIV_CYCLES - 1)) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                res_next.window_mean = mean;
                if ({1'b0, cmd_reg.interval} > limit) begin
                    res_next.status = ST_INJECTION;
                end else begin
                    ram_we                    = 1'b1;
                    sum_next[cmd_reg.slot]    = sum - SUM_W'(old_reg)
                                                + SUM_W'(cmd_reg.interval);
                    cursor_next[cmd_reg.slot] = cur_inc;
                    res_next.status           = ST_NORMAL;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        cmd_reg     <= cmd_next;
        old_reg     <= old_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        cursor_reg  <= cursor_next;
        warm_reg    <= warm_next;
        sum_reg     <= sum_next;
        if (!rstn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
endmodule
`default_nettype wire

FILE: rtl/core/frame_interval_injection_detector.sv
// Per-connection frame interval anomaly detector. Each input item is one
// received link-layer frame; each produces exactly one result item, in order.
// A front stage looks up the connection context by access address (16 slots,
// lowest free slot allocated on a miss, never freed) and classifies the frame
// in the cycle it is accepted; a 4-entry command queue feeds a back stage that
// owns the per-connection interval rings (one single-port-per-side RAM of
// slots x window entries) with a running window sum per slot. The back stage
// steps IDLE, PREP, OUT for not-slave, table-full and skipped frames, adds
// READ for a learning frame (one registered ring read, then write), and adds
// READ, DIV, CMP for a compared frame, DIV being the divide-by-window unit
// that retires 8 quotient bits a cycle over the 37-bit sum. The front keeps
// accepting while the queue has room and the output register waits. No
// clearing pass after reset: a context's cursor, warm-up count and sum are
// cleared when the slot is allocated, and the ring is fully written before
// its first mean. threshold is written through cfg_we/cfg_wdata (reset 100);
// the user must write it only while the block is idle; the block won't check.
`default_nettype none
module frame_interval_injection_detector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] access_address, [63:32] frame_interval, [71:64] missed_packets
    input  wire logic [71:0] s_axis_tdata,
    // [0] is_slave, [1] interval_valid
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] window_mean, [35:32] context_slot, [39:36] zero
    output logic [39:0]      m_axis_tdata,
    // [2:0] status
    output logic [2:0]       m_axis_tuser
);
    import fiid_pkg::*;

    logic [THRESH_W-1:0] threshold_reg, threshold_next;
    in_item_t            in_item;
    logic                q_push;
    cmd_t                q_push_cmd;
    logic                q_full;
    logic                q_pop;
    cmd_t                q_pop_cmd;
    logic                q_not_empty;
    result_t             result;

    // threshold register, no read-back
    assign threshold_next = cfg_we ? cfg_wdata : threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else begin
            threshold_reg <= threshold_next;
        end
    end

    // unpack the input item
    assign in_item.access_address = s_axis_tdata[31:0];
    assign in_item.frame_interval = s_axis_tdata[63:32];
    assign in_item.missed_packets = s_axis_tdata[71:64];
    assign in_item.is_slave       = s_axis_tuser[0];
    assign in_item.interval_valid = s_axis_tuser[1];

    // lookup, allocation and classification
    fiid_front u_front (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd),
        .q_full   (q_full)
    );

    fiid_queue u_queue (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (q_pop_cmd),
        .not_empty (q_not_empty)
    );

    // ring update, windowed mean and threshold compare
    fiid_back u_back (
        .clk        (aclk),
        .rstn       (aresetn),
        .cmd_valid  (q_not_empty),
        .cmd        (q_pop_cmd),
        .cmd_pop    (q_pop),
        .threshold  (threshold_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {4'b0000, result.context_slot, result.window_mean};
    assign m_axis_tuser = result.status;

    // not-slave and table-full results carry no slot and no mean
    a_no_ctx_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_NOT_SLAVE || m_axis_tuser == ST_FULL)
        |-> m_axis_tdata == '0)
        else $error("payload set on a result without context");

    // mean is reported only when a comparison was made
    a_mean_only_compared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_SKIPPED || m_axis_tuser == ST_LEARNING)
        |-> m_axis_tdata[31:0] == '0)
        else $error("window mean set without comparison");

    // front never pushes into a full queue
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("command queue overflow");

endmodule
`default_nettype wire

FILE: tb/fiid_checker.sv
`timescale 1ns / 100ps
module fiid_checker
    import fiid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [31:0] access_address, [63:32] frame_interval, [71:64] missed_packets
    input  logic [71:0] s_axis_tdata,
    // [0] is_slave, [1] interval_valid
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] window_mean, [35:32] context_slot, [39:36] zero
    input  logic [39:0] m_axis_tdata,
    // [2:0] status
    input  logic [2:0]  m_axis_tuser,
    output int unsigned failures,
    output int unsigned outstanding
);

    logic [THRESH_W-1:0]   margin;
    logic [ADDR_W-1:0]     ctx_key  [CONTEXT_SLOTS];
    logic                  ctx_live [CONTEXT_SLOTS];
    logic [INTERVAL_W-1:0] ring     [CONTEXT_SLOTS][WINDOW_DEPTH];
    int unsigned           cursor   [CONTEXT_SLOTS];
    int unsigned           warm     [CONTEXT_SLOTS];
    result_t               due_verdicts [$];

    initial begin
        failures    = 0;
        outstanding = 0;
    end

    function automatic void push_interval(int unsigned s, logic [INTERVAL_W-1:0] v);
        ring[s][cursor[s]] = v;
        cursor[s] = (cursor[s] + 1) % WINDOW_DEPTH;
    endfunction

    function automatic result_t judge_frame(in_item_t f);
        result_t     r;
        int unsigned s;
        int unsigned i;
        bit          hit;
        logic [63:0] sum;
        logic [63:0] mean;
        r = '0;
        r.status = ST_NOT_SLAVE;
        if (!f.is_slave) begin
            return r;
        end
        hit = 1'b0;
        s = 0;
        for (i = 0; i < CONTEXT_SLOTS && !hit; i++) begin
            if (ctx_live[i] && ctx_key[i] == f.access_address) begin
                s   = i;
                hit = 1'b1;
            end
        end
        // new key: lowest free slot, kept even if the frame is skipped
        for (i = 0; i < CONTEXT_SLOTS && !hit; i++) begin
            if (!ctx_live[i]) begin
                s           = i;
                hit         = 1'b1;
                ctx_live[i] = 1'b1;
                ctx_key[i]  = f.access_address;
                cursor[i]   = 0;
                warm[i]     = 0;
            end
        end
        if (!hit) begin
            r.status = ST_FULL;
            return r;
        end
        r.context_slot = s[CTX_SLOT_W-1:0];
        if (!f.interval_valid || f.missed_packets != 0) begin
            r.status = ST_SKIPPED;
            return r;
        end
        if (warm[s] < WARMUP_WINDOWS) begin
            if (cursor[s] == WINDOW_DEPTH - 1) begin
                warm[s]++;
            end
            push_interval(s, f.frame_interval);
            r.status = ST_LEARNING;
            return r;
        end
        // full-width sum and compare, no 32-bit wrap
        sum = '0;
        for (i = 0; i < WINDOW_DEPTH; i++) begin
            sum += 64'(ring[s][i]);
        end
        mean = sum / WINDOW_DEPTH;
        r.window_mean = mean[MEAN_W-1:0];
        if (64'(f.frame_interval) > mean + 64'(margin)) begin
            r.status = ST_INJECTION;
        end else begin
            push_interval(s, f.frame_interval);
            r.status = ST_NORMAL;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        in_item_t frame;
        result_t  want;
        if (!aresetn) begin
            margin = THRESHOLD_RESET;
            foreach (ctx_live[i]) begin
                ctx_live[i] = 1'b0;
            end
            due_verdicts.delete();
        end else begin
            if (cfg_we) begin
                margin = cfg_wdata;
            end
            // results first: a result can never belong to an item taken at the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_verdicts.size() == 0) begin
                    $error("unexpected result item: status %0d tdata %h",
                           m_axis_tuser, m_axis_tdata);
                    failures++;
                end else begin
                    want = due_verdicts.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        failures++;
                    end
                    if (m_axis_tdata[31:0] !== want.window_mean) begin
                        $error("window_mean: expected %0d, got %0d",
                               want.window_mean, m_axis_tdata[31:0]);
                        failures++;
                    end
                    if (m_axis_tdata[35:32] !== want.context_slot) begin
                        $error("context_slot: expected %0d, got %0d",
                               want.context_slot, m_axis_tdata[35:32]);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                frame.access_address = s_axis_tdata[31:0];
                frame.frame_interval = s_axis_tdata[63:32];
                frame.missed_packets = s_axis_tdata[71:64];
                frame.is_slave       = s_axis_tuser[0];
                frame.interval_valid = s_axis_tuser[1];
                due_verdicts.push_back(judge_frame(frame));
            end
        end
        outstanding <= due_verdicts.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import fiid_pkg::*;

    localparam int DRAIN_CYCLES = 32;    // a few compare items' worth of back-stage time
    localparam int HOLD_CYCLES  = 300;   // long sink hold-off to back the block up
    localparam int STALL_LIMIT  = 5000;  // cycles with no handshake at all

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [31:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] access_address, [63:32] frame_interval, [71:64] missed_packets
    logic [71:0] s_axis_tdata  = '0;
    // [0] is_slave, [1] interval_valid
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] window_mean, [35:32] context_slot, [39:36] zero
    logic [39:0] m_axis_tdata;
    // [2:0] status
    logic [2:0]  m_axis_tuser;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned results_taken = 0;
    int unsigned quiet_cycles  = 0;
    logic        calm          = 1'b0;  // high: neither side idles

    // Connection pool: slot k ends up owning pool[k] after the directed part.
    // Slot 0 runs near the top of the 32-bit range (sum needs > 32 bits),
    // slot 1 has zero base and jitter, slot 2 a constant base so mean + threshold
    // is known exactly and spikes land right on the boundary.
    logic [31:0] pool      [CONTEXT_SLOTS];
    logic [31:0] base      [CONTEXT_SLOTS];
    logic [31:0] jit       [CONTEXT_SLOTS];
    logic [31:0] threshold_now = THRESHOLD_RESET;

    always #5 aclk = ~aclk;

    frame_interval_injection_detector u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    fiid_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // Alternate between idling stretches and full-rate stretches.
    initial begin : pace
        forever begin
            repeat ($urandom_range(100, 500)) @(posedge aclk);
            calm <= 1'b1;
            repeat ($urandom_range(20, 120)) @(posedge aclk);
            calm <= 1'b0;
        end
    end

    // Result sink: random stalls per item, plus two long hold-offs while the
    // source keeps offering, so the command queue and input back up.
    initial begin : sink
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_taken == 200 || results_taken == 900) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                stall = calm ? 0 : $urandom_range(0, 13);
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            results_taken++;
        end
    end

    // Watchdog: no handshake of any kind for too long ends the run.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit known_key(logic [31:0] a, int unsigned upto);
        int unsigned i;
        for (i = 0; i < upto; i++) begin
            if (pool[i] == a) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Interval for a well-formed frame on connection k: mostly base + jitter,
    // sometimes a spike just past mean + threshold, and on the ordinary
    // connections now and then an arbitrary 32-bit value.
    function automatic logic [31:0] pick_interval(int unsigned k);
        logic [63:0] v;
        if (k >= 3 && $urandom_range(0, 19) == 0) begin
            v = 64'($urandom);
        end else if ($urandom_range(0, 9) == 0) begin
            v = 64'(base[k]) + 64'(threshold_now) + 64'(jit[k]) + 64'($urandom_range(0, 1));
        end else begin
            v = 64'(base[k]) + 64'($urandom_range(0, jit[k]));
        end
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Offer one item after a random gap; returns at the edge it is taken.
    task automatic send_frame(input logic [31:0] addr, input bit slave, input bit iv,
                              input logic [31:0] intv, input logic [7:0] miss);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {miss, intv, addr};
        s_axis_tuser  <= {iv, slave};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stop offering and wait until every expected result is out, then let
    // the back stage settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [31:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        threshold_now = v;
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned k;
        logic [31:0] a;
        pick = $urandom_range(0, 99);
        // most traffic on a few connections so they get well past warm-up
        k = ($urandom_range(0, 2) != 0) ? $urandom_range(0, 3)
                                        : $urandom_range(0, CONTEXT_SLOTS - 1);
        if (pick < 80) begin
            send_frame(pool[k], 1'b1, 1'b1, pick_interval(k), 8'd0);
        end else if (pick < 86) begin
            // skipped: missed packets or no interval
            if ($urandom_range(0, 1) != 0) begin
                send_frame(pool[k], 1'b1, 1'b1, pick_interval(k), $urandom_range(1, 255));
            end else begin
                send_frame(pool[k], 1'b1, 1'b0, $urandom, 8'd0);
            end
        end else if (pick < 91) begin
            // master-side frames, anything in the fields
            send_frame($urandom, 1'b0, $urandom_range(0, 1), $urandom, $urandom_range(0, 255));
        end else if (pick < 95) begin
            // unknown connection once the table is full
            do a = $urandom; while (known_key(a, CONTEXT_SLOTS));
            send_frame(a, 1'b1, $urandom_range(0, 1), $urandom, $urandom_range(0, 255));
        end else begin
            // noise on the ordinary connections only, so the fixed-pattern
            // rings of slots 0..2 stay predictable
            k = $urandom_range(3, CONTEXT_SLOTS - 1);
            send_frame(pool[k], 1'b1, $urandom_range(0, 1), $urandom,
                       ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int unsigned k;
        int unsigned p;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < CONTEXT_SLOTS; k++) begin
            do pool[k] = $urandom; while (known_key(pool[k], k));
        end
        base[0] = 32'hFFFF_FF00;  jit[0] = 32'hFF;
        base[1] = 32'd0;          jit[1] = 32'd0;
        base[2] = 32'd5000;       jit[2] = 32'd0;
        for (k = 3; k < CONTEXT_SLOTS; k++) begin
            base[k] = $urandom_range(200, 2_000_000);
            jit[k]  = base[k] / 8;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part ---
        // master-side frame with every field at its top value
        send_frame(32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'hFF);
        // first frame of each connection: skipped, fills slots 0..15 in order
        for (k = 0; k < CONTEXT_SLOTS; k++) begin
            send_frame(pool[k], 1'b1, 1'b0, $urandom, 8'd0);
        end
        // one more connection: table full
        send_frame(32'hA5A5_5A5A ^ pool[2], 1'b1, 1'b1, 32'd1000, 8'd0);
        // missed packets at both ends of the range, and no interval with misses
        send_frame(pool[3], 1'b1, 1'b1, 32'd1000, 8'hFF);
        send_frame(pool[3], 1'b1, 1'b1, 32'd1000, 8'd1);
        send_frame(pool[3], 1'b1, 1'b0, 32'd0, 8'h80);
        // learning with interval extremes
        send_frame(pool[4], 1'b1, 1'b1, 32'd0, 8'd0);
        send_frame(pool[4], 1'b1, 1'b1, 32'hFFFF_FFFF, 8'd0);
        // known key but master side: ignored
        send_frame(pool[5], 1'b0, 1'b0, 32'd0, 8'd0);

        // --- random part, one threshold per phase ---
        for (p = 0; p < 5; p++) begin
            if (p != 0) begin
                drain_pipeline();
                case (p)
                    1: set_threshold(32'd0);
                    2: set_threshold(32'hFFFF_FFFF);
                    3: set_threshold($urandom);
                    default: set_threshold($urandom_range(1, 5000));
                endcase
            end
            repeat ((p == 0) ? 300 : (p == 4) ? 350 : 250) random_frame();
        end

        drain_pipeline();
        if (failures == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
